// ----- design/lttr_pkg.sv -----
package lttr_pkg;

    localparam int SLOTS       = 16;
    localparam int TICKET_BITS = 16;
    localparam int ID_BITS     = 16;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef logic [TICKET_BITS-1:0] tkt_t;
    typedef logic [TICKET_BITS:0]   tkt_wide_t;
    typedef logic [ID_BITS-1:0]     tid_t;
    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [CNT_W-1:0]       cnt_t;

    // Highest last ticket that still leaves next_ticket representable.
    localparam tkt_wide_t TLIMIT = {1'b0, {(TICKET_BITS-1){1'b1}}, 1'b0};

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_GIVE,
        OP_REMOVE,
        OP_DRAW
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_NOT_FOUND,
        STATUS_FULL,
        STATUS_OVERFLOW
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } fsm_state_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] thread_id;
        logic        is_lottery;
        logic [15:0] ticket_count;
        logic [15:0] ticket;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] owner_id;
        logic [15:0] first_ticket;
        logic [15:0] last_ticket;
        logic [15:0] next_ticket;
        logic [4:0]  lottery_count;
    } rsp_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
        idx_t idx;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

endpackage

// ----- design/lttr_req_if.sv -----
interface lttr_req_if;
    import lttr_pkg::*;

    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/lttr_rsp_if.sv -----
interface lttr_rsp_if;
    import lttr_pkg::*;

    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/lttr_ctrl.sv -----
module lttr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  lttr_pkg::stat_t stat,
    output lttr_pkg::cmd_t  cmd
);
    import lttr_pkg::*;

    localparam idx_t LAST_IDX = IDX_W'(SLOTS - 1);

    fsm_state_t state_reg;
    fsm_state_t state_next;
    idx_t       idx_reg;
    idx_t       idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                    idx_next   = '0;
                end
            end
            S_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = (state_reg == S_IDLE);
        cmd.start  = (state_reg == S_IDLE) && in_valid;
        cmd.scan   = (state_reg == S_SCAN);
        cmd.commit = (state_reg == S_COMMIT) && stat.out_free;
        cmd.idx    = idx_reg;
    end

    a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (state_reg == S_SCAN) && (idx_reg == '0))
        else $error("accepted beat did not start a scan at entry zero");

    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && (idx_reg == LAST_IDX) |=> (state_reg == S_COMMIT))
        else $error("scan did not end in commit after the last entry");

    a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (state_reg == S_IDLE) && in_ready)
        else $error("controller not ready after commit");

endmodule

// ----- design/lttr_dpath.sv -----
module lttr_dpath (
    input  logic            clk,
    input  logic            rst_n,
    input  lttr_pkg::req_t  req_data,
    input  lttr_pkg::cmd_t  cmd,
    input  logic            rsp_ready,
    output logic            rsp_valid,
    output lttr_pkg::rsp_t  rsp_data,
    output lttr_pkg::stat_t stat
);
    import lttr_pkg::*;

    // Table.
    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] lot_reg;
    tid_t             thread_reg [SLOTS];
    tkt_t             first_reg  [SLOTS];
    tkt_t             last_reg   [SLOTS];
    cnt_t             total_reg;

    // Latched request.
    op_t  op_reg;
    tid_t id_reg;
    logic lot_in_reg;
    tkt_t cnt_reg;
    tkt_t tk_reg;

    // Scan results.
    tkt_t max_reg;
    logic free_found_reg;
    idx_t free_idx_reg;
    logic hit_found_reg;
    idx_t hit_idx_reg;
    logic hit_lot_reg;
    tid_t hit_thread_reg;
    tkt_t hit_first_reg;
    tkt_t hit_last_reg;

    logic rsp_valid_reg;
    rsp_t rsp_reg;

    // Entry under the scan pointer.
    logic e_valid;
    logic e_lot;
    tid_t e_thread;
    tkt_t e_first;
    tkt_t e_last;
    logic e_match;

    // Commit decision.
    tkt_wide_t        sum_w;
    logic             over;
    tkt_t             size;
    status_t          status;
    tid_t             owner;
    tkt_t             first_o;
    tkt_t             last_o;
    tkt_t             new_max;
    cnt_t             total_next;
    logic             do_insert;
    logic             do_give;
    logic             do_remove;
    logic [SLOTS-1:0] shift_en;

    assign e_valid  = valid_reg[cmd.idx];
    assign e_lot    = lot_reg[cmd.idx];
    assign e_thread = thread_reg[cmd.idx];
    assign e_first  = first_reg[cmd.idx];
    assign e_last   = last_reg[cmd.idx];

    // Draw looks for the owning range, the other operations for the thread.
    always_comb
    begin
        if (op_reg == OP_DRAW)
        begin
            e_match = e_valid && e_lot && (e_first <= tk_reg) && (tk_reg <= e_last);
        end
        else
        begin
            e_match = e_valid && (e_thread == id_reg);
        end
    end

    assign sum_w = {1'b0, max_reg} + {1'b0, cnt_reg};
    assign over  = (sum_w > TLIMIT);
    assign size  = hit_last_reg - hit_first_reg + 1'b1;

    always_comb
    begin
        status    = STATUS_OK;
        owner     = '0;
        first_o   = '0;
        last_o    = '0;
        new_max   = max_reg;
        do_insert = 1'b0;
        do_give   = 1'b0;
        do_remove = 1'b0;
        unique case (op_reg)
            OP_INSERT:
            begin
                if (!free_found_reg)
                begin
                    status = STATUS_FULL;
                end
                else if (lot_in_reg && ((cnt_reg == '0) || over))
                begin
                    status = STATUS_OVERFLOW;
                end
                else
                begin
                    do_insert = 1'b1;
                    owner     = id_reg;
                    if (lot_in_reg)
                    begin
                        first_o = max_reg + 1'b1;
                        last_o  = sum_w[TICKET_BITS-1:0];
                        new_max = sum_w[TICKET_BITS-1:0];
                    end
                end
            end
            OP_GIVE:
            begin
                if (!hit_found_reg || !hit_lot_reg)
                begin
                    status = STATUS_NOT_FOUND;
                end
                else if (over)
                begin
                    status = STATUS_OVERFLOW;
                end
                else
                begin
                    do_give = 1'b1;
                    owner   = id_reg;
                    first_o = hit_first_reg;
                    last_o  = hit_last_reg + cnt_reg;
                    new_max = sum_w[TICKET_BITS-1:0];
                end
            end
            OP_REMOVE:
            begin
                if (!hit_found_reg)
                begin
                    status = STATUS_NOT_FOUND;
                end
                else
                begin
                    do_remove = 1'b1;
                    owner     = id_reg;
                    if (hit_lot_reg)
                    begin
                        first_o = hit_first_reg;
                        last_o  = hit_last_reg;
                        // Ranges tile from ticket one, so the top drops by the size.
                        new_max = max_reg - size;
                    end
                end
            end
            OP_DRAW:
            begin
                if (hit_found_reg)
                begin
                    owner   = hit_thread_reg;
                    first_o = hit_first_reg;
                    last_o  = hit_last_reg;
                end
                else
                begin
                    status = STATUS_NOT_FOUND;
                end
            end
            default:
            begin
                status = STATUS_NOT_FOUND;
            end
        endcase
    end

    always_comb
    begin
        total_next = total_reg;
        if (do_insert && lot_in_reg)
        begin
            total_next = total_reg + 1'b1;
        end
        else if (do_remove && hit_lot_reg)
        begin
            total_next = total_reg - 1'b1;
        end
    end

    // Ranges above the affected entry move together.
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            shift_en[i] = valid_reg[i] && lot_reg[i] && (first_reg[i] > hit_last_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            lot_reg        <= '0;
            total_reg      <= '0;
            free_found_reg <= 1'b0;
            hit_found_reg  <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                free_found_reg <= 1'b0;
                hit_found_reg  <= 1'b0;
            end
            else if (cmd.scan)
            begin
                if (!e_valid)
                begin
                    free_found_reg <= 1'b1;
                end
                if (e_match)
                begin
                    hit_found_reg <= 1'b1;
                end
            end

            if (cmd.commit)
            begin
                total_reg <= total_next;
                if (do_insert)
                begin
                    valid_reg[free_idx_reg] <= 1'b1;
                    lot_reg[free_idx_reg]   <= lot_in_reg;
                end
                if (do_remove)
                begin
                    valid_reg[hit_idx_reg] <= 1'b0;
                    lot_reg[hit_idx_reg]   <= 1'b0;
                end
            end

            if (cmd.commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg     <= req_data.op;
            id_reg     <= ID_BITS'(req_data.thread_id);
            lot_in_reg <= req_data.is_lottery;
            cnt_reg    <= TICKET_BITS'(req_data.ticket_count);
            tk_reg     <= TICKET_BITS'(req_data.ticket);
            max_reg    <= '0;
        end
        else if (cmd.scan)
        begin
            if (e_valid && e_lot && (e_last > max_reg))
            begin
                max_reg <= e_last;
            end
            if (!e_valid && !free_found_reg)
            begin
                free_idx_reg <= cmd.idx;
            end
            if (e_match && !hit_found_reg)
            begin
                hit_idx_reg    <= cmd.idx;
                hit_lot_reg    <= e_lot;
                hit_thread_reg <= e_thread;
                hit_first_reg  <= e_first;
                hit_last_reg   <= e_last;
            end
        end

        if (cmd.commit)
        begin
            if (do_insert)
            begin
                thread_reg[free_idx_reg] <= id_reg;
                first_reg[free_idx_reg]  <= first_o;
                last_reg[free_idx_reg]   <= last_o;
            end
            for (int i = 0; i < SLOTS; i++)
            begin
                if (do_give)
                begin
                    if (IDX_W'(i) == hit_idx_reg)
                    begin
                        last_reg[i] <= last_reg[i] + cnt_reg;
                    end
                    else if (shift_en[i])
                    begin
                        first_reg[i] <= first_reg[i] + cnt_reg;
                        last_reg[i]  <= last_reg[i] + cnt_reg;
                    end
                end
                else if (do_remove && hit_lot_reg && shift_en[i])
                begin
                    first_reg[i] <= first_reg[i] - size;
                    last_reg[i]  <= last_reg[i] - size;
                end
            end

            rsp_reg.status        <= status;
            rsp_reg.owner_id      <= 16'(owner);
            rsp_reg.first_ticket  <= 16'(first_o);
            rsp_reg.last_ticket   <= 16'(last_o);
            rsp_reg.next_ticket   <= 16'(new_max + 1'b1);
            rsp_reg.lottery_count <= 5'(total_next);
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign rsp_data      = rsp_reg;
    assign stat.out_free = !rsp_valid_reg || rsp_ready;

    a_total_count: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg == CNT_W'($countones(valid_reg & lot_reg)))
        else $error("lottery entry count out of step with the table");

    a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && hit_found_reg |-> valid_reg[hit_idx_reg])
        else $error("matched entry is not valid at commit");

    a_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && free_found_reg |-> !valid_reg[free_idx_reg])
        else $error("free slot found by the scan is occupied at commit");

endmodule

// ----- design/lottery_ticket_range_table.sv -----
// Lottery ticket range table: a table of SLOTS thread entries in which every
// lottery entry owns a contiguous ticket range, the ranges together covering
// tickets 1 up to next_ticket-1. One request beat (insert, give tickets, remove,
// draw) yields exactly one response beat. Each request is handled by a controller
// that walks the table one entry per cycle to find the highest last ticket, the
// lowest free slot and the matching thread or ticket owner, then commits the
// change, moving all later ranges at once. A new request is accepted only once
// the scan and commit of the previous one are done. The response sits in an
// output register, so a new request is taken while the previous response waits;
// only a second finished response stalls the commit.
// The table is empty after reset and needs no clearing pass.
module lottery_ticket_range_table (
    input  logic       clk,
    input  logic       rst_n,
    lttr_req_if.sink   req,
    lttr_rsp_if.source rsp
);
    import lttr_pkg::*;

    // Command and status between the sequencer and the table datapath.
    cmd_t  cmd;
    stat_t stat;

    // The controller owns the scan pointer and decides when a beat is taken
    // and when the result may be committed to the output register.
    lttr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the table, gathers the scan results, applies the
    // update and drives the response beat.
    lttr_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req.data),
        .cmd       (cmd),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .rsp_data  (rsp.data),
        .stat      (stat)
    );

endmodule

// ----- tb/tb_lottery_ticket_range_table.sv -----
module tb_lottery_ticket_range_table;
    import lttr_pkg::*;

    // Run shape. The drain pauses are sized in request times of the table, since it
    // takes up a new request only after the previous one has been committed.
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 4 * (SLOTS + 2);
    localparam int PHASE_ITEMS  = 406;
    localparam int ID_POOL      = 12;
    localparam int STALL_AT     = 1000;
    localparam int LONG_STALL   = 400;

    // Scoreboard: keeps its own copy of the slot table, works out the response
    // for every accepted request beat and checks responses in order.
    class range_table_scoreboard;
        bit   slot_used [SLOTS];
        bit   slot_lot  [SLOTS];
        tid_t slot_tid  [SLOTS];
        tkt_t slot_lo   [SLOTS];
        tkt_t slot_hi   [SLOTS];
        cnt_t lot_entries;
        rsp_t expected_rsp [$];
        int   mismatches;

        function new();
            foreach (slot_used[i])
            begin
                slot_used[i] = 1'b0;
                slot_lot[i]  = 1'b0;
                slot_tid[i]  = '0;
                slot_lo[i]   = '0;
                slot_hi[i]   = '0;
            end
            lot_entries = '0;
            mismatches  = 0;
        endfunction

        function tkt_t top_ticket();
            tkt_t m;
            m = '0;
            for (int i = 0; i < SLOTS; i++)
                if (slot_used[i] && slot_lot[i] && slot_hi[i] > m)
                    m = slot_hi[i];
            return m;
        endfunction

        function tkt_t next_free_ticket();
            return top_ticket() + 16'd1;
        endfunction

        function int pending();
            return expected_rsp.size();
        endfunction

        // Give and remove act on the lowest-numbered slot holding the thread.
        function int find_slot(tid_t id);
            for (int i = 0; i < SLOTS; i++)
                if (slot_used[i] && slot_tid[i] == id)
                    return i;
            return -1;
        endfunction

        function void note_request(req_t r);
            rsp_t      res;
            int        s;
            tkt_wide_t f;
            tkt_t      prev;
            tkt_t      span;
            res = '0;
            res.status = STATUS_OK;
            unique case (r.op)
                OP_INSERT:
                begin
                    s = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (!slot_used[i] && s < 0)
                            s = i;
                    if (s < 0)
                        res.status = STATUS_FULL;
                    else if (r.is_lottery)
                    begin
                        f = tkt_wide_t'(top_ticket()) + 1'b1;
                        if (r.ticket_count == '0 || f + r.ticket_count - 1'b1 > TLIMIT)
                            res.status = STATUS_OVERFLOW;
                        else
                        begin
                            res.first_ticket = tkt_t'(f);
                            res.last_ticket  = tkt_t'(f + r.ticket_count - 1'b1);
                        end
                    end
                    if (res.status == STATUS_OK)
                    begin
                        slot_used[s] = 1'b1;
                        slot_lot[s]  = r.is_lottery;
                        slot_tid[s]  = r.thread_id;
                        slot_lo[s]   = res.first_ticket;
                        slot_hi[s]   = res.last_ticket;
                        if (r.is_lottery)
                            lot_entries++;
                        res.owner_id = r.thread_id;
                    end
                end
                OP_GIVE:
                begin
                    s = find_slot(r.thread_id);
                    if (s < 0 || !slot_lot[s])
                        res.status = STATUS_NOT_FOUND;
                    else if (tkt_wide_t'(top_ticket()) + r.ticket_count > TLIMIT)
                        res.status = STATUS_OVERFLOW;
                    else
                    begin
                        prev = slot_hi[s];
                        slot_hi[s] = prev + r.ticket_count;
                        for (int i = 0; i < SLOTS; i++)
                            if (i != s && slot_used[i] && slot_lot[i] && slot_lo[i] > prev)
                            begin
                                slot_lo[i] += r.ticket_count;
                                slot_hi[i] += r.ticket_count;
                            end
                        res.owner_id     = r.thread_id;
                        res.first_ticket = slot_lo[s];
                        res.last_ticket  = slot_hi[s];
                    end
                end
                OP_REMOVE:
                begin
                    s = find_slot(r.thread_id);
                    if (s < 0)
                        res.status = STATUS_NOT_FOUND;
                    else
                    begin
                        res.owner_id = r.thread_id;
                        slot_used[s] = 1'b0;
                        if (slot_lot[s])
                        begin
                            res.first_ticket = slot_lo[s];
                            res.last_ticket  = slot_hi[s];
                            span = slot_hi[s] - slot_lo[s] + 16'd1;
                            for (int i = 0; i < SLOTS; i++)
                                if (slot_used[i] && slot_lot[i] && slot_lo[i] > slot_hi[s])
                                begin
                                    slot_lo[i] -= span;
                                    slot_hi[i] -= span;
                                end
                            lot_entries--;
                        end
                        slot_lot[s] = 1'b0;
                    end
                end
                default:
                begin
                    res.status = STATUS_NOT_FOUND;
                    for (int i = 0; i < SLOTS; i++)
                        if (res.status == STATUS_NOT_FOUND && slot_used[i] && slot_lot[i]
                            && slot_lo[i] <= r.ticket && r.ticket <= slot_hi[i])
                        begin
                            res.status       = STATUS_OK;
                            res.owner_id     = slot_tid[i];
                            res.first_ticket = slot_lo[i];
                            res.last_ticket  = slot_hi[i];
                        end
                end
            endcase
            res.next_ticket   = next_free_ticket();
            res.lottery_count = lot_entries;
            expected_rsp.push_back(res);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (expected_rsp.size() == 0)
            begin
                $error("response beat with nothing outstanding: status %0d owner %0d",
                       got.status, got.owner_id);
                mismatches++;
                return;
            end
            want = expected_rsp.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("owner_id", 32'(want.owner_id), 32'(got.owner_id));
            compare_field("first_ticket", 32'(want.first_ticket), 32'(got.first_ticket));
            compare_field("last_ticket", 32'(want.last_ticket), 32'(got.last_ticket));
            compare_field("next_ticket", 32'(want.next_ticket), 32'(got.next_ticket));
            compare_field("lottery_count", 32'(want.lottery_count),
                          32'(got.lottery_count));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    lttr_req_if req_ch ();
    lttr_rsp_if rsp_ch ();

    lottery_ticket_range_table u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    range_table_scoreboard sb = new();

    // Thread identifiers used by well-formed traffic. Keeping the set small makes
    // give and remove find their targets and produces duplicate inserts.
    tid_t id_pool [ID_POOL];

    // Idle rates in percent for the request sender and the response receiver.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // Count of accepted request beats; the receiver uses it to place its long stall.
    int sent_beats = 0;

    always #6 clk = ~clk;

    // Responses are checked at the rising edge on which the handshake completes.
    always @(posedge clk)
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.data);

    // Receiver. Ready changes only at the falling edge. Once, partway into the
    // run, it holds ready low for a long stretch while the sender keeps offering
    // requests, so the output register fills and the block stalls its input.
    initial
    begin : receiver
        int stall_left;
        bit stall_done;
        stall_left = 0;
        stall_done = 1'b0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!stall_done && sent_beats >= STALL_AT)
            begin
                stall_left = LONG_STALL;
                stall_done = 1'b1;
            end
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Offers one request beat and returns on a falling edge once it has been taken.
    // Valid stays high on return so back-to-back beats need no extra edge; it is
    // lowered only when the sender idles or drains.
    task automatic send_request(input req_t r);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(r);
        sent_beats++;
        @(negedge clk);
    endtask

    task automatic send_op(input op_t op, input tid_t id, input logic lot,
                           input tkt_t count, input tkt_t tk);
        req_t r;
        r.op           = op;
        r.thread_id    = id;
        r.is_lottery   = lot;
        r.ticket_count = count;
        r.ticket       = tk;
        send_request(r);
    endtask

    // The sender stops and waits until every expected response has come back,
    // then lets the block settle for a few request times.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    // Directed part: edge values of the fields and each corner of the table.
    task automatic directed_requests();
        // Empty table: draw and remove find nothing.
        send_op(OP_DRAW, 16'h0000, 1'b0, 16'h0000, 16'h0000);
        send_op(OP_REMOVE, 16'h0000, 1'b0, 16'h0000, 16'h0000);
        // A zero-ticket lottery insert is an empty range and is rejected.
        send_op(OP_INSERT, 16'hFFFF, 1'b1, 16'h0000, 16'h0000);
        // The largest legal range takes every ticket up to 65534.
        send_op(OP_INSERT, 16'hFFFF, 1'b1, 16'hFFFE, 16'hFFFF);
        send_op(OP_INSERT, 16'h0001, 1'b1, 16'h0001, 16'h0000);
        send_op(OP_DRAW, 16'h0000, 1'b0, 16'h0000, 16'hFFFE);
        send_op(OP_DRAW, 16'h0000, 1'b0, 16'h0000, 16'hFFFF);
        // Giving nothing succeeds; giving one more ticket overflows.
        send_op(OP_GIVE, 16'hFFFF, 1'b0, 16'h0000, 16'h0000);
        send_op(OP_GIVE, 16'hFFFF, 1'b0, 16'h0001, 16'h0000);
        // Round-robin entries hold no tickets and cannot be given any.
        send_op(OP_INSERT, 16'h1234, 1'b0, 16'hFFFF, 16'h0000);
        send_op(OP_GIVE, 16'h1234, 1'b1, 16'h0001, 16'h0000);
        send_op(OP_REMOVE, 16'hFFFF, 1'b0, 16'h0000, 16'h0000);
        // A duplicate identifier lands in the lower free slot, so give and the
        // first remove hit the lottery copy and the second one the round-robin.
        send_op(OP_INSERT, 16'h1234, 1'b1, 16'h000A, 16'h0000);
        send_op(OP_GIVE, 16'h1234, 1'b0, 16'h0005, 16'h0000);
        send_op(OP_REMOVE, 16'h1234, 1'b0, 16'h0000, 16'h0000);
        send_op(OP_REMOVE, 16'h1234, 1'b0, 16'h0000, 16'h0000);
        // Fill every slot, then one more insert finds the table full.
        for (int i = 0; i <= SLOTS; i++)
            send_op(OP_INSERT, id_pool[i % ID_POOL], i[0], tkt_t'(i % 3 + 1), 16'h0000);
    endtask

    // Random request: mostly well-formed traffic on the identifier pool, with
    // random content in the fields the operation ignores.
    function automatic req_t random_request();
        req_t r;
        int   pick;
        r.thread_id    = tid_t'($urandom_range(0, 65535));
        r.is_lottery   = 1'($urandom_range(0, 1));
        r.ticket_count = tkt_t'($urandom_range(0, 65535));
        r.ticket       = tkt_t'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        if (pick < 35)
            r.op = OP_INSERT;
        else if (pick < 55)
            r.op = OP_GIVE;
        else if (pick < 75)
            r.op = OP_REMOVE;
        else
            r.op = OP_DRAW;
        // Inserts always use the pool so that the table never clogs with entries
        // nobody removes; give and remove sometimes name an unknown thread.
        if (r.op == OP_INSERT || $urandom_range(0, 99) < 85)
            r.thread_id = id_pool[$urandom_range(0, ID_POOL - 1)];
        if (r.op == OP_INSERT)
            r.is_lottery = ($urandom_range(0, 99) < 70);
        pick = $urandom_range(0, 99);
        if (pick < 8)
            r.ticket_count = '0;
        else if (pick < 70)
            r.ticket_count = tkt_t'($urandom_range(1, 40));
        else if (pick < 90)
            r.ticket_count = tkt_t'($urandom_range(1, 3000));
        // Draws mostly aim at the assigned ticket space, including its edges.
        pick = $urandom_range(0, 99);
        if (pick < 80)
            r.ticket = tkt_t'($urandom_range(0, sb.next_free_ticket()));
        else if (pick < 88)
            r.ticket = '0;
        return r;
    endfunction

    initial
    begin : stimulus
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        foreach (id_pool[i])
            id_pool[i] = tid_t'($urandom_range(0, 65535));
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        tx_idle_pct = 20;
        rx_idle_pct = 57;
        directed_requests();
        wait_drained();

        // Three random phases: sender idles lightly and receiver heavily, then
        // the reverse, then full rate on both sides. The long receiver stall
        // falls in the last phase.
        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 57 : 0;
            rx_idle_pct = (ph == 0) ? 57 : (ph == 1) ? 20 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(random_request());
            wait_drained();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin : watchdog
        #7200000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
